FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SWPF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define SWPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked while reset is held.
`define SWPF_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/swpf_pkg.sv
// Types and constants for the servo write packet framer.
package swpf_pkg;

    localparam logic       OP_POSITION = 1'b0;
    localparam logic       OP_MODE     = 1'b1;

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] INSTR_WRITE = 8'h03;
    localparam logic [7:0] POS_LEN     = 8'h09;
    localparam logic [7:0] POS_ADDR    = 8'h2A;
    localparam logic [7:0] MODE_LEN    = 8'h04;
    localparam logic [7:0] MODE_ADDR   = 8'h21;

    // byte positions within a packet
    localparam int          IDX_W        = 4;
    localparam logic [3:0]  IDX_HDR0     = 4'd0;
    localparam logic [3:0]  IDX_HDR1     = 4'd1;
    localparam logic [3:0]  IDX_ID       = 4'd2;
    localparam logic [3:0]  IDX_LEN      = 4'd3;
    localparam logic [3:0]  IDX_INSTR    = 4'd4;
    localparam logic [3:0]  IDX_ADDR     = 4'd5;
    localparam logic [3:0]  IDX_P0       = 4'd6;
    localparam logic [3:0]  IDX_P1       = 4'd7;
    localparam logic [3:0]  IDX_P2       = 4'd8;
    localparam logic [3:0]  IDX_P3       = 4'd9;
    localparam logic [3:0]  IDX_P4       = 4'd10;
    localparam logic [3:0]  IDX_P5       = 4'd11;
    localparam logic [3:0]  IDX_POS_LAST = 4'd12;
    localparam logic [3:0]  IDX_MODE_LAST = 4'd7;

    localparam int IN_DATA_W = 64;
    localparam int IN_USER_W = 1;
    localparam int OUT_DATA_W = 8;

    // one classified request waiting for the byte sequencer
    typedef struct packed {
        logic        op;
        logic [7:0]  servo_id;
        logic [15:0] goal_position;
        logic [15:0] move_time;
        logic [15:0] move_speed;
        logic [7:0]  run_mode;
        logic [7:0]  checksum;
    } t_desc;

endpackage

FILE: rtl/swpf_front.sv
// Front end: takes requests, precomputes the checksum, holds one descriptor.
module swpf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [swpf_pkg::IN_DATA_W-1:0] i_data,
    input  logic [swpf_pkg::IN_USER_W-1:0] i_user,
    output logic                        o_push,
    output swpf_pkg::t_desc             o_desc,
    input  logic                        i_push_ready
);
    import swpf_pkg::*;

    logic   r_valid;
    t_desc  r_desc;
    t_desc  n_desc;
    logic [7:0] w_sum;

    always_comb begin
        n_desc.op            = i_user[0];
        n_desc.servo_id      = i_data[7:0];
        n_desc.goal_position = i_data[23:8];
        n_desc.move_time     = i_data[39:24];
        n_desc.move_speed    = i_data[55:40];
        n_desc.run_mode      = i_data[63:56];
        if (n_desc.op == OP_MODE) begin
            w_sum = n_desc.servo_id + MODE_LEN + INSTR_WRITE + MODE_ADDR + n_desc.run_mode;
        end else begin
            w_sum = n_desc.servo_id + POS_LEN + INSTR_WRITE + POS_ADDR
                  + n_desc.goal_position[7:0] + n_desc.goal_position[15:8]
                  + n_desc.move_time[7:0] + n_desc.move_time[15:8]
                  + n_desc.move_speed[7:0] + n_desc.move_speed[15:8];
        end
        n_desc.checksum = ~w_sum;
    end

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_desc  = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_desc <= n_desc;
        end
    end

endmodule

FILE: rtl/swpf_queue.sv
// Short descriptor queue between the front end and the byte sequencer.
module swpf_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  swpf_pkg::t_desc i_desc,
    output logic            o_valid,
    input  logic            i_pop,
    output swpf_pkg::t_desc o_desc
);
    import swpf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_desc       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

FILE: rtl/swpf_back.sv
// Back end: walks a descriptor byte by byte into the output register.
module swpf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  swpf_pkg::t_desc               i_desc,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [swpf_pkg::OUT_DATA_W-1:0] o_data,
    output logic                          o_last
);
    import swpf_pkg::*;

    t_desc            r_cur;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_last;
    logic             w_adv;
    logic             w_last;
    logic [7:0]       w_byte;

    assign w_adv   = r_busy && (!r_out_valid || i_ready);
    assign w_last  = (r_cur.op == OP_MODE) ? (r_idx == IDX_MODE_LAST)
                                           : (r_idx == IDX_POS_LAST);
    assign o_q_pop = i_q_valid && (!r_busy || (w_adv && w_last));

    always_comb begin
        case (r_idx)
            IDX_HDR0:  w_byte = HDR_BYTE;
            IDX_HDR1:  w_byte = HDR_BYTE;
            IDX_ID:    w_byte = r_cur.servo_id;
            IDX_LEN:   w_byte = (r_cur.op == OP_MODE) ? MODE_LEN : POS_LEN;
            IDX_INSTR: w_byte = INSTR_WRITE;
            IDX_ADDR:  w_byte = (r_cur.op == OP_MODE) ? MODE_ADDR : POS_ADDR;
            IDX_P0:    w_byte = (r_cur.op == OP_MODE) ? r_cur.run_mode
                                                      : r_cur.goal_position[7:0];
            IDX_P1:    w_byte = (r_cur.op == OP_MODE) ? r_cur.checksum
                                                      : r_cur.goal_position[15:8];
            IDX_P2:    w_byte = r_cur.move_time[15:8];
            IDX_P3:    w_byte = r_cur.move_time[7:0];
            IDX_P4:    w_byte = r_cur.move_speed[15:8];
            IDX_P5:    w_byte = r_cur.move_speed[7:0];
            IDX_POS_LAST: w_byte = r_cur.checksum;
            default:   w_byte = HDR_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= IDX_HDR0;
            end else if (w_adv && w_last) begin
                r_busy <= 1'b0;
            end else if (w_adv) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_desc;
        end
        if (w_adv) begin
            r_out_data <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

FILE: rtl/servo_write_packet_framer.sv
// Top level of the servo write packet framer.
// Usage:
//  - Slave stream: one write request per beat. tuser = operation (0 position,
//    1 mode); tdata = servo_id, goal_position, move_time, move_speed, run_mode.
//  - Master stream: one packet byte per beat in tdata, tlast on the checksum.
//  - Position requests give 13 bytes, mode requests give 8 bytes.
//  - Path to the first header byte when the block is empty: front register,
//    queue, sequencer descriptor register, output register.
//  - Throughput: the byte sequencer emits one byte per cycle while the master
//    side takes them; packets follow without gaps.
//  - The front register and the descriptor queue take further requests while a
//    packet is still being sent; s_axis_tready drops once they are full.
//  - A stalled master side holds the output byte; the sequencer waits with it.
//  - Synchronous active-low reset empties the queue and drops master tvalid.
module servo_write_packet_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] servo_id, [23:8] goal_position, [39:24] move_time,
    // [55:40] move_speed, [63:56] run_mode
    input  logic [63:0] i_s_axis_tdata,
    // [0] operation
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]  o_m_axis_tdata,
    // last_byte
    output logic        o_m_axis_tlast
);
    import swpf_pkg::*;

    logic  w_push;
    logic  w_push_ready;
    t_desc w_front_desc;
    logic  w_q_valid;
    logic  w_q_pop;
    t_desc w_q_desc;

    swpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .i_user       (i_s_axis_tuser),
        .o_push       (w_push),
        .o_desc       (w_front_desc),
        .i_push_ready (w_push_ready)
    );

    swpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_desc       (w_front_desc),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_desc       (w_q_desc)
    );

    swpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_desc    (w_q_desc),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

FILE: rtl/swpf_checker.sv
// Port-level checker for the servo write packet framer, bound to the top.
`include "assert_macros.svh"

module swpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] i_m_axis_tdata,
    input logic       i_m_axis_tlast
);
    logic       w_beat;
    logic [3:0] r_beat;

    assign w_beat = i_m_axis_tvalid && i_m_axis_tready;

    // byte count within the current packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (w_beat && i_m_axis_tlast) begin
            r_beat <= '0;
        end else if (w_beat) begin
            r_beat <= r_beat + 1'b1;
        end
    end

    `SWPF_ASSERT_NEXT_RST(a_reset_idle, !i_rst_n, !i_m_axis_tvalid)
    `SWPF_ASSERT_NEXT(a_stall_hold, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast))
    `SWPF_ASSERT_IMPL(a_last_pos, i_m_axis_tvalid && i_m_axis_tlast, r_beat == 4'd7 || r_beat == 4'd12)
    `SWPF_ASSERT_IMPL(a_len_bound, i_m_axis_tvalid, r_beat <= 4'd12)
    `SWPF_ASSERT_IMPL(a_header, i_m_axis_tvalid && (r_beat == 4'd0 || r_beat == 4'd1), i_m_axis_tdata == 8'hFF)

endmodule

bind servo_write_packet_framer swpf_checker u_swpf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

FILE: tb/sv/servo_write_packet_framer_test.sv
// Self-checking testbench for the servo write packet framer.
`timescale 1ns / 100ps

module servo_write_packet_framer_test;
    import swpf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;
    localparam int RANDOM_REQS = 150;

    typedef struct {
        logic        op;
        logic [7:0]  servo_id;
        logic [15:0] goal_position;
        logic [15:0] move_time;
        logic [15:0] move_speed;
        logic [7:0]  run_mode;
    } t_servo_req;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_packet_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // [7:0] servo_id, [23:8] goal_position, [39:24] move_time,
    // [55:40] move_speed, [63:56] run_mode
    logic [63:0] i_s_axis_tdata;
    // [0] operation
    logic [0:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [7:0] tx_byte
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;

    t_packet_byte expected_bytes[$];
    int           mismatch_count = 0;
    int           bytes_seen = 0;
    int           quiet_cycles = 0;

    // transmitter-side flow control
    bit tx_stall_en = 0;
    int tx_hold_left = 0;
    int tx_gap_left = 0;
    // request-side gaps
    bit req_gap_en = 0;

    servo_write_packet_framer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected packet bytes for one write request.
    function automatic void build_packet(input t_servo_req r);
        logic [7:0] pkt[$];
        logic [7:0] sum;
        int n;
        pkt.push_back(HDR_BYTE);
        pkt.push_back(HDR_BYTE);
        pkt.push_back(r.servo_id);
        if (r.op == OP_POSITION) begin
            pkt.push_back(POS_LEN);
            pkt.push_back(INSTR_WRITE);
            pkt.push_back(POS_ADDR);
            pkt.push_back(r.goal_position[7:0]);
            pkt.push_back(r.goal_position[15:8]);
            pkt.push_back(r.move_time[15:8]);
            pkt.push_back(r.move_time[7:0]);
            pkt.push_back(r.move_speed[15:8]);
            pkt.push_back(r.move_speed[7:0]);
        end else begin
            pkt.push_back(MODE_LEN);
            pkt.push_back(INSTR_WRITE);
            pkt.push_back(MODE_ADDR);
            pkt.push_back(r.run_mode);
        end
        sum = 8'h00;
        for (int k = 2; k < pkt.size(); k++)
            sum += pkt[k];
        pkt.push_back(~sum);
        n = pkt.size();
        for (int k = 0; k < n; k++)
            expected_bytes.push_back('{data: pkt[k], last: (k == n - 1)});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at a falling edge.
    task automatic send_request(input t_servo_req r);
        i_s_axis_tdata  = {r.run_mode, r.move_speed, r.move_time, r.goal_position,
                           r.servo_id};
        i_s_axis_tuser  = r.op;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        build_packet(r);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = {$urandom, $urandom};
        i_s_axis_tuser  = 1'($urandom_range(0, 1));
        if (req_gap_en && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
    endtask

    task automatic wait_for_packets();
        while (expected_bytes.size() != 0)
            @(negedge i_clk);
    endtask

    // Transmitter enable is read at falling edges, so change it at a rising one.
    task automatic set_idling(input bit req_gaps, input bit tx_stalls);
        @(posedge i_clk);
        tx_stall_en = tx_stalls;
        req_gap_en  = req_gaps;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick8();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 8'hFF));
        endcase
    endfunction

    function automatic t_servo_req random_request();
        t_servo_req r;
        r.op            = $urandom_range(0, 1) ? OP_MODE : OP_POSITION;
        r.servo_id      = pick8();
        r.goal_position = pick16();
        r.move_time     = pick16();
        r.move_speed    = pick16();
        r.run_mode      = pick8();
        return r;
    endfunction

    task automatic test_directed();
        t_servo_req dir[$];
        set_idling(0, 0);
        dir.push_back('{OP_POSITION, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00});
        dir.push_back('{OP_POSITION, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF});
        // byte order of each 16-bit parameter
        dir.push_back('{OP_POSITION, 8'h01, 16'h12AB, 16'h34CD, 16'h56EF, 8'h00});
        dir.push_back('{OP_POSITION, 8'hFE, 16'h0001, 16'h8000, 16'h0080, 8'h5A});
        dir.push_back('{OP_POSITION, 8'h7F, 16'h8000, 16'h0001, 16'h0100, 8'hA5});
        // run_mode must not leak into a position packet
        dir.push_back('{OP_POSITION, 8'h80, 16'h55AA, 16'hAA55, 16'h0F0F, 8'hFF});
        dir.push_back('{OP_MODE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00});
        dir.push_back('{OP_MODE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF});
        // position fields must not leak into a mode packet
        dir.push_back('{OP_MODE, 8'h01, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00});
        dir.push_back('{OP_MODE, 8'hB7, 16'h1234, 16'h5678, 16'h9ABC, 8'h01});
        dir.push_back('{OP_MODE, 8'h3C, 16'h0000, 16'h0000, 16'h0000, 8'h80});
        // checksum sum wraps past 8 bits
        dir.push_back('{OP_MODE, 8'hD7, 16'h0000, 16'h0000, 16'h0000, 8'hFF});
        dir.push_back('{OP_POSITION, 8'hC3, 16'hF0F0, 16'hFF00, 16'h00FF, 8'h00});
        foreach (dir[i])
            send_request(dir[i]);
        wait_for_packets();
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < RANDOM_REQS / 25; chunk++) begin
            // some chunks run with no idling at all
            set_idling($urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0);
            repeat (25)
                send_request(random_request());
        end
        wait_for_packets();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        @(posedge i_clk);
        tx_hold_left = LONG_HOLD;
        @(negedge i_clk);
        // sender keeps offering while the transmitter holds off
        repeat (8)
            send_request(random_request());
        // then pause until the backlog has drained
        wait_for_packets();
        repeat (6)
            send_request(random_request());
        wait_for_packets();
    endtask

    task automatic test_back_to_back();
        set_idling(0, 0);
        repeat (30)
            send_request(random_request());
        wait_for_packets();
    endtask

    // transmitter side: random stall bursts and the long hold
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (tx_hold_left > 0) begin
                i_m_axis_tready = 1'b0;
                tx_hold_left--;
            end else if (tx_gap_left > 0) begin
                i_m_axis_tready = 1'b0;
                tx_gap_left--;
            end else if (tx_stall_en && $urandom_range(0, 6) == 0) begin
                i_m_axis_tready = 1'b0;
                tx_gap_left = $urandom_range(1, 13) - 1;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_packet_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h with no packet pending",
                                          o_m_axis_tdata));
            end else begin
                want = expected_bytes.pop_front();
                if (o_m_axis_tdata !== want.data)
                    report_mismatch($sformatf("byte %0d tx_byte: expected %02h got %02h",
                                              bytes_seen, want.data, o_m_axis_tdata));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch($sformatf("byte %0d last_byte: expected %0b got %0b",
                                              bytes_seen, want.last, o_m_axis_tlast));
            end
            bytes_seen++;
        end
    end

    // watchdog: cycles with no transfer on either side
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("servo_write_packet_framer verification failed");
        $finish;
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_traffic();
        test_back_to_back();

        // let any stray byte show up before judging
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("servo_write_packet_framer verification clean");
        end else begin
            $display("servo_write_packet_framer verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/swpf_pkg.sv
rtl/swpf_front.sv
rtl/swpf_queue.sv
rtl/swpf_back.sv
rtl/servo_write_packet_framer.sv
rtl/swpf_checker.sv
tb/sv/servo_write_packet_framer_test.sv
